### rtl/core/hue_to_rgb_color_map_assert.svh
// Assertion macros used by the color map RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef HUE_TO_RGB_COLOR_MAP_ASSERT_SVH
`define HUE_TO_RGB_COLOR_MAP_ASSERT_SVH

// Clocked check, quiet while reset is high.
`define H2RGB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds through reset.
`define H2RGB_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/h2rgb_pkg.sv
// Shared constants for the hue to RGB color map.
// No dependencies; used by h2rgb_map and hue_to_rgb_color_map.
package h2rgb_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int POS_WIDTH         = 32;

   // Configuration register indexes
   localparam int                      CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SATURATION = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BRIGHTNESS = 2'd1;

endpackage

### rtl/core/h2rgb_map.sv
// Combinational hue map: clamp, segment select, ramp blend, channel routing.
// Depends on h2rgb_pkg.
module h2rgb_map #(
   parameter int FRAC_BITS = h2rgb_pkg::FRAC_BITS_DEFAULT
) (
   input  logic signed [h2rgb_pkg::POS_WIDTH-1:0] position,
   input  logic [FRAC_BITS:0]                     saturation,
   input  logic [FRAC_BITS:0]                     brightness,
   output logic [FRAC_BITS:0]                     red,
   output logic [FRAC_BITS:0]                     green,
   output logic [FRAC_BITS:0]                     blue
);

   localparam int LW = FRAC_BITS + 1;
   localparam int SW = LW + 2;
   localparam int PW = 2 * LW + 2;
   localparam int PL = h2rgb_pkg::POS_WIDTH - 1;

   localparam logic [LW-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [PW-1:0] HALF = PW'(ONE) >> 1;

   localparam logic [2:0] SEG_0 = 3'd0;
   localparam logic [2:0] SEG_1 = 3'd1;
   localparam logic [2:0] SEG_2 = 3'd2;
   localparam logic [2:0] SEG_3 = 3'd3;
   localparam logic [2:0] SEG_4 = 3'd4;
   localparam logic [2:0] SEG_5 = 3'd5;
   localparam logic [2:0] SEG_COUNT = 3'd6;

   logic [LW-1:0]        pos;
   logic [SW-1:0]        scaled;
   logic [2:0]           seg;
   logic [LW-1:0]        frac;
   logic [LW-1:0]        sat;
   logic [LW-1:0]        peak;
   logic [LW-1:0]        floor_lv;
   logic signed [LW:0]   diff;
   logic signed [PW-1:0] prod;
   logic [PW-1:0]        acc_rise;
   logic [PW-1:0]        acc_fall;
   logic [LW-1:0]        rise;
   logic [LW-1:0]        fall;

   // clamp to [0, one]
   always_comb begin
      if (position[PL]) begin
         pos = '0;
      end else if (position[PL-1:0] > PL'(ONE)) begin
         pos = ONE;
      end else begin
         pos = position[LW-1:0];
      end
   end

   // pos * 6 as shift-add
   assign scaled = SW'({pos, 2'b00}) + SW'({pos, 1'b0});

   // position one lands at the end of the last segment
   always_comb begin
      if (scaled[FRAC_BITS +: 3] >= SEG_COUNT) begin
         seg  = SEG_5;
         frac = ONE;
      end else begin
         seg  = scaled[FRAC_BITS +: 3];
         frac = {1'b0, scaled[FRAC_BITS-1:0]};
      end
   end

   assign sat      = (saturation > ONE) ? ONE : saturation;
   assign peak     = (brightness > ONE) ? ONE : brightness;
   assign floor_lv = ONE - sat;

   // L*(one-f) + V*f == L*one + (V-L)*f ; the falling ramp mirrors it from V
   assign diff     = $signed({1'b0, peak}) - $signed({1'b0, floor_lv});
   assign prod     = diff * $signed({1'b0, frac});
   assign acc_rise = PW'({floor_lv, {FRAC_BITS{1'b0}}}) + HALF + $unsigned(prod);
   assign acc_fall = PW'({peak, {FRAC_BITS{1'b0}}}) + HALF - $unsigned(prod);
   assign rise     = acc_rise[FRAC_BITS +: LW];
   assign fall     = acc_fall[FRAC_BITS +: LW];

   always_comb begin
      case (seg)
         SEG_0: begin
            red = peak;     green = rise;     blue = floor_lv;
         end
         SEG_1: begin
            red = fall;     green = peak;     blue = floor_lv;
         end
         SEG_2: begin
            red = floor_lv; green = peak;     blue = rise;
         end
         SEG_3: begin
            red = floor_lv; green = fall;     blue = peak;
         end
         SEG_4: begin
            red = rise;     green = floor_lv; blue = peak;
         end
         default: begin
            red = peak;     green = floor_lv; blue = fall;
         end
      endcase
   end

endmodule

### rtl/core/hue_to_rgb_color_map.sv
// Hue to RGB color map: input register, map logic, result register.
// rsp_tvalid rises once an accepted req item has passed the input register, then the result register;
// throughput 1 transaction per cycle while the receiver does not stall.
// The rate is set by the single map pass (one 18x18 multiply) between two registers.
// Reset (synchronous, active high) empties both stages and sets saturation and
// brightness to one. Depends on h2rgb_pkg, h2rgb_map and the assertion header.
`include "hue_to_rgb_color_map_assert.svh"

module hue_to_rgb_color_map #(
   parameter int FRAC_BITS = h2rgb_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // input stream
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [h2rgb_pkg::POS_WIDTH-1:0]       req_tdata,  // [31:0] position
   // result stream
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // red, green, blue from bit 0 up, FRAC_BITS+1 bits each, zero padded
   output logic [((3*(FRAC_BITS+1)+7)/8)*8-1:0]  rsp_tdata,
   // configuration writes
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [h2rgb_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [FRAC_BITS:0]                    csr_wdata
);

   localparam int LW    = FRAC_BITS + 1;
   localparam int RSP_W = ((3 * LW + 7) / 8) * 8;
   localparam logic [LW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

   // stage valids
   logic in_valid_ff, in_valid_in;
   logic out_valid_ff, out_valid_in;

   // payload
   logic signed [h2rgb_pkg::POS_WIDTH-1:0] in_pos_ff;
   logic [RSP_W-1:0]                       out_data_ff;
   logic [LW-1:0]                          saturation_ff;
   logic [LW-1:0]                          brightness_ff;

   logic          advance;  // result stage can take a new item
   logic          load_in;
   logic [LW-1:0] red;
   logic [LW-1:0] green;
   logic [LW-1:0] blue;
   logic          levels_ok;

   // Result register frees up when empty or when its transaction completes;
   // the input stage can then refill in the same cycle.
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign load_in    = req_tvalid && req_tready;

   assign in_valid_in  = req_tready ? req_tvalid : 1'b1;
   assign out_valid_in = advance ? in_valid_ff : 1'b1;

   assign csr_ready = 1'b1;

   h2rgb_map #(
      .FRAC_BITS (FRAC_BITS)
   ) u_map (
      .position   (in_pos_ff),
      .saturation (saturation_ff),
      .brightness (brightness_ff),
      .red        (red),
      .green      (green),
      .blue       (blue)
   );

   // control and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         saturation_ff <= ONE;
         brightness_ff <= ONE;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               h2rgb_pkg::CSR_SATURATION: saturation_ff <= csr_wdata;
               h2rgb_pkg::CSR_BRIGHTNESS: brightness_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (load_in) begin
         in_pos_ff <= req_tdata;
      end
      if (advance && in_valid_ff) begin
         out_data_ff <= RSP_W'({blue, green, red});
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   assign levels_ok = (rsp_tdata[LW-1:0] <= ONE) &&
                      (rsp_tdata[2*LW-1:LW] <= ONE) &&
                      (rsp_tdata[3*LW-1:2*LW] <= ONE);

   // an accepted item always occupies the input stage next cycle
   `H2RGB_ASSERT(a_load_fills, clock, reset, load_in |=> in_valid_ff, "input stage lost an item")
   // a held item moves to the result register once the result side frees
   `H2RGB_ASSERT(a_fill_out, clock, reset, (in_valid_ff && advance) |=> rsp_tvalid, "no result")
   // an empty input stage never refuses a transaction
   `H2RGB_ASSERT_ALWAYS(a_empty_ready, clock, !in_valid_ff |-> req_tready, "empty stage stalled")
   // every channel level stays within one
   `H2RGB_ASSERT(a_levels, clock, reset, rsp_tvalid |-> levels_ok, "level above one")

endmodule

### bench/tb.sv
// Self-checking bench for hue_to_rgb_color_map: drives positions, checks RGB results.
// Depends on h2rgb_pkg and the hue_to_rgb_color_map RTL; the expected colors come from
// its own fixed-point model of the rainbow map in the rgb_checker class below.
`timescale 1ns / 100ps

class rgb_checker;
   localparam int FB = h2rgb_pkg::FRAC_BITS_DEFAULT;
   localparam longint unsigned ONE = 64'd1 << FB;

   typedef enum int {
      SEG_RED_YELLOW   = 0,
      SEG_YELLOW_GREEN = 1,
      SEG_GREEN_CYAN   = 2,
      SEG_CYAN_BLUE    = 3,
      SEG_BLUE_MAGENTA = 4,
      SEG_MAGENTA_RED  = 5
   } hue_seg_type;

   typedef struct packed {
      logic [FB:0] red;
      logic [FB:0] green;
      logic [FB:0] blue;
   } rgb_type;

   logic [FB:0] saturation;
   logic [FB:0] brightness;
   rgb_type     expected_rgb[$];
   int          mismatches;

   function new();
      saturation = ONE[FB:0];
      brightness = ONE[FB:0];
      mismatches = 0;
   endfunction

   function void write_reg(logic [h2rgb_pkg::CSR_INDEX_WIDTH-1:0] idx, logic [FB:0] val);
      if (idx == h2rgb_pkg::CSR_SATURATION)
         saturation = val;
      else if (idx == h2rgb_pkg::CSR_BRIGHTNESS)
         brightness = val;
   endfunction

   function longint unsigned clip_one(longint unsigned v);
      return (v > ONE) ? ONE : v;
   endfunction

   // lo at f = 0, hi at f = one, round to nearest, ties up
   function longint unsigned ramp(longint unsigned lo, longint unsigned hi,
                                  longint unsigned f);
      return (lo * (ONE - f) + hi * f + (ONE >> 1)) >> FB;
   endfunction

   function rgb_type predict_rgb(logic [31:0] pos);
      longint unsigned peak, floor_lv, p, scaled, seg, fr, rise, fall;
      longint unsigned r, g, b;
      rgb_type res;
      peak     = clip_one(64'(brightness));
      floor_lv = ONE - clip_one(64'(saturation));
      if (pos[31])
         p = 0;
      else if (64'(pos) > ONE)
         p = ONE;
      else
         p = 64'(pos);
      scaled = p * 6;
      seg    = scaled >> FB;
      fr     = scaled & (ONE - 1);
      // exactly one stays at the end of the last segment (red), no wrap
      if (seg >= 6) begin
         seg = 5;
         fr  = ONE;
      end
      rise = ramp(floor_lv, peak, fr);
      fall = ramp(floor_lv, peak, ONE - fr);
      case (hue_seg_type'(seg))
         SEG_RED_YELLOW: begin
            r = peak;     g = rise;     b = floor_lv;
         end
         SEG_YELLOW_GREEN: begin
            r = fall;     g = peak;     b = floor_lv;
         end
         SEG_GREEN_CYAN: begin
            r = floor_lv; g = peak;     b = rise;
         end
         SEG_CYAN_BLUE: begin
            r = floor_lv; g = fall;     b = peak;
         end
         SEG_BLUE_MAGENTA: begin
            r = rise;     g = floor_lv; b = peak;
         end
         default: begin
            r = peak;     g = floor_lv; b = fall;
         end
      endcase
      res.red   = r[FB:0];
      res.green = g[FB:0];
      res.blue  = b[FB:0];
      return res;
   endfunction

   function void note_position(logic [31:0] pos);
      expected_rgb.push_back(predict_rgb(pos));
   endfunction

   function void check_rgb(logic [3*FB+2:0] data);
      rgb_type got, want;
      got.red   = data[FB:0];
      got.green = data[2*FB+1:FB+1];
      got.blue  = data[3*FB+2:2*FB+2];
      if (expected_rgb.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected rgb result: r=%0d g=%0d b=%0d", got.red, got.green, got.blue);
         return;
      end
      want = expected_rgb.pop_front();
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
         mismatches++;
         if (mismatches <= 10)
            $display("rgb mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                     want.red, want.green, want.blue, got.red, got.green, got.blue);
      end
   endfunction

   function int pending();
      return expected_rgb.size();
   endfunction
endclass

module tb;
   localparam int FB     = h2rgb_pkg::FRAC_BITS_DEFAULT;
   localparam int DATA_W = ((3 * (FB + 1) + 7) / 8) * 8;
   localparam int N_CORNERS = 22;

   // receiver back-pressure patterns, picked from a free-running cycle count
   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_COIN,
      STALL_PERIODIC,
      STALL_HEAVY
   } stall_mode_type;

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  req_tvalid = 1'b0;
   logic                                  req_tready;
   logic [h2rgb_pkg::POS_WIDTH-1:0]       req_tdata = '0;   // [31:0] position
   logic                                  rsp_tvalid;
   logic                                  rsp_tready = 1'b0;
   logic [DATA_W-1:0]                     rsp_tdata;        // red, green, blue from bit 0 up
   logic                                  csr_valid = 1'b0;
   logic                                  csr_ready;
   logic [h2rgb_pkg::CSR_INDEX_WIDTH-1:0] csr_index = h2rgb_pkg::CSR_SATURATION;
   logic [FB:0]                           csr_wdata = '0;
   logic [15:0]                           cyc = '0;

   rgb_checker chk = new();

   // Segment boundaries around k/6, the clamp edges, exactly one, and sign extremes.
   logic [31:0] corner_positions [N_CORNERS] = '{
      32'h0000_0000, 32'h0000_0001, 32'd10922, 32'd10923, 32'h0000_4000,
      32'd21845, 32'd21846, 32'd32767, 32'd32768, 32'd43690,
      32'd43691, 32'h0000_C000, 32'd54613, 32'd54614, 32'd65535,
      32'h0001_0000, 32'h0001_0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
      32'h00FF_0000, 32'hAAAA_5555
   };

   hue_to_rgb_color_map dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Receiver: stall pattern follows bits 9:8 of the cycle count; one mode never stalls.
   always @(posedge clock) begin
      cyc <= cyc + 16'd1;
      case (stall_mode_type'(cyc[9:8]))
         STALL_NONE:     rsp_tready <= 1'b1;
         STALL_COIN:     rsp_tready <= ($urandom_range(0, 1) == 1);
         STALL_PERIODIC: rsp_tready <= (cyc[1:0] != 2'd3);
         default:        rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // Check every accepted result transaction against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         chk.check_rgb(rsp_tdata[3*FB+2:0]);
   end

   // Mostly in-range positions (that is where the segments live); the rest is
   // full-range noise, negatives and values just above one to hit the clamp.
   function automatic logic [31:0] pick_position();
      case ($urandom_range(0, 9))
         0:       return $urandom;
         1:       return 32'h8000_0000 | $urandom;
         2:       return 32'h0001_0000 + $urandom_range(1, 255);
         default: return $urandom_range(0, 65536);
      endcase
   endfunction

   // Mostly legal levels, sometimes above one to exercise the saturation.
   function automatic logic [FB:0] pick_level();
      if ($urandom_range(0, 4) == 0)
         return (FB+1)'($urandom_range(65537, 131071));
      return (FB+1)'($urandom_range(0, 65536));
   endfunction

   // Wait until every predicted result has come back.
   task automatic wait_drain();
      while (chk.pending() != 0)
         @(posedge clock);
   endtask

   // Two back-to-back register writes; csr_valid stays high across both.
   task automatic write_levels(input logic [FB:0] sat, input logic [FB:0] bright);
      csr_valid <= 1'b1;
      csr_index <= h2rgb_pkg::CSR_SATURATION;
      csr_wdata <= sat;
      do @(posedge clock); while (!csr_ready);
      chk.write_reg(h2rgb_pkg::CSR_SATURATION, sat);
      csr_index <= h2rgb_pkg::CSR_BRIGHTNESS;
      csr_wdata <= bright;
      do @(posedge clock); while (!csr_ready);
      chk.write_reg(h2rgb_pkg::CSR_BRIGHTNESS, bright);
      csr_valid <= 1'b0;
   endtask

   // Send the corner positions, then n_random random ones, in bursts with gaps.
   // With no_gaps set the whole phase streams back to back.
   task automatic run_phase(input int n_random, input bit no_gaps);
      int          burst;
      int          total;
      logic [31:0] pos;
      total = N_CORNERS + n_random;
      burst = $urandom_range(1, 40);
      for (int i = 0; i < total; i++) begin
         pos = (i < N_CORNERS) ? corner_positions[i] : pick_position();
         req_tvalid <= 1'b1;
         req_tdata  <= pos;
         do @(posedge clock); while (!req_tready);
         chk.note_position(pos);
         burst--;
         // a gap is never empty, so valid never drops and rises in one step
         if (!no_gaps && burst == 0 && i < total - 1) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst = $urandom_range(1, 40);
         end
      end
      req_tvalid <= 1'b0;
   endtask

   initial begin
      logic [FB:0] sat;
      logic [FB:0] bright;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset levels first (saturation and brightness both one)
      run_phase(130, 1'b0);

      for (int ph = 1; ph < 9; ph++) begin
         case (ph)
            1: begin sat = 17'd0;      bright = 17'd65536;  end // floor at one, all white
            2: begin sat = 17'd65536;  bright = 17'd0;      end // peak at zero, all black
            3: begin sat = 17'h1FFFF;  bright = 17'h1FFFF; end // both above one
            4: begin sat = 17'd32768;  bright = 17'd20000;  end // peak below floor
            5: begin sat = 17'd0;      bright = 17'd0;      end
            default: begin
               sat    = pick_level();
               bright = pick_level();
            end
         endcase
         // registers only change with the pipe empty
         wait_drain();
         write_levels(sat, bright);
         run_phase(130, (ph % 3) == 2);
      end

      wait_drain();
      repeat (8) @(posedge clock);
      if (chk.mismatches == 0 && chk.pending() == 0)
         $display("hue_to_rgb_color_map test passed");
      else
         $display("hue_to_rgb_color_map test failed");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run (~1400 items, heavy stalls).
   initial begin
      #5_000_000;
      $display("hue_to_rgb_color_map test failed");
      $finish;
   end
endmodule

### filelist.f
+incdir+rtl/core
rtl/core/h2rgb_pkg.sv
rtl/core/h2rgb_map.sv
rtl/core/hue_to_rgb_color_map.sv
bench/tb.sv
